// ----- design/u8xe_pkg.sv -----
// Shared constants and helpers for the UTF-8 / XML escape encoder.
package u8xe_pkg;

  localparam int unsigned CpWidth    = 31;
  localparam int unsigned DigitWidth = 6;
  localparam int unsigned NumDigits  = 6;
  localparam int unsigned SrWidth    = DigitWidth * NumDigits;

  typedef logic [2:0] kind_t;

  localparam kind_t KIND_ASCII = 3'd0;
  localparam kind_t KIND_UTF   = 3'd1;
  localparam kind_t KIND_AMP   = 3'd2;
  localparam kind_t KIND_LT    = 3'd3;
  localparam kind_t KIND_GT    = 3'd4;

  localparam logic [7:0] CHAR_AMP  = 8'd38;
  localparam logic [7:0] CHAR_LT   = 8'd60;
  localparam logic [7:0] CHAR_GT   = 8'd62;
  localparam logic [7:0] CHAR_SEMI = 8'd59;
  localparam logic [7:0] CONT_TAG  = 8'h80;

  // Entity text byte at position idx: "&amp;", "&lt;" or "&gt;".
  function automatic logic [7:0] entity_byte(input kind_t kind, input logic [2:0] idx);
    logic [7:0] b;
    b = CHAR_SEMI;
    case (idx)
      3'd0: b = CHAR_AMP;
      3'd1: begin
        case (kind)
          KIND_AMP: b = 8'd97;   // a
          KIND_LT:  b = 8'd108;  // l
          default:  b = 8'd103;  // g
        endcase
      end
      3'd2: b = (kind == KIND_AMP) ? 8'd109 : 8'd116;  // m / t
      3'd3: b = (kind == KIND_AMP) ? 8'd112 : CHAR_SEMI;  // p / ;
      default: b = CHAR_SEMI;
    endcase
    return b;
  endfunction

  // Lead byte length marker for an n-byte sequence.
  function automatic logic [7:0] lead_marker(input logic [2:0] n);
    logic [7:0] m;
    case (n)
      3'd2:    m = 8'hC0;
      3'd3:    m = 8'hE0;
      3'd4:    m = 8'hF0;
      3'd5:    m = 8'hF8;
      3'd6:    m = 8'hFC;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

// ----- design/utf8_xml_escape_encoder_unit.sv -----
// UTF-8 encoder with XML entity escaping, one output byte per cycle unless the output stalls.
// A character's first byte is generated from the registered state, then registered.
// Each character is n = 1..6 bytes (4 or 5 for entities), taken from a shift register
// of 6-bit digits; the next character is accepted as the last byte is generated.
// Reset (rst_ni low, asynchronous): the encoder goes idle and the output empties.
module utf8_xml_escape_encoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [30:0] code_point_i,
  input  logic        last_char_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        last_byte_o,
  output logic        string_end_o
);

  localparam int unsigned SrW = u8xe_pkg::SrWidth;
  localparam int unsigned DW  = u8xe_pkg::DigitWidth;

  logic                busy_q, busy_d;
  logic [2:0]          rem_q, rem_d;
  logic [2:0]          idx_q, idx_d;
  logic                first_q, first_d;
  u8xe_pkg::kind_t     kind_q, kind_d;
  logic [7:0]          marker_q, marker_d;
  logic [SrW-1:0]      sr_q, sr_d;
  logic                lastc_q, lastc_d;

  logic                out_valid_q, out_valid_d;
  logic [7:0]          out_byte_q, out_byte_d;
  logic                last_byte_q, last_byte_d;
  logic                string_end_q, string_end_d;

  logic                gen;
  logic                finish;
  logic                accept;
  logic [2:0]          n_len;
  logic [SrW-1:0]      cp_ext;
  logic [DW-1:0]       top_digit;
  logic [7:0]          gen_byte;

  assign gen       = busy_q && (!out_valid_q || !out_stall_i);
  assign finish    = gen && (rem_q == 3'd1);
  assign in_stall_o = busy_q && !finish;
  assign accept    = in_valid_i && !in_stall_o;
  assign cp_ext    = {{(SrW - u8xe_pkg::CpWidth){1'b0}}, code_point_i};
  assign top_digit = sr_q[SrW-1 -: DW];

  always_comb begin
    if (code_point_i < 31'h80)           n_len = 3'd1;
    else if (code_point_i < 31'h800)     n_len = 3'd2;
    else if (code_point_i < 31'h10000)   n_len = 3'd3;
    else if (code_point_i < 31'h200000)  n_len = 3'd4;
    else if (code_point_i < 31'h4000000) n_len = 3'd5;
    else                                 n_len = 3'd6;
  end

  always_comb begin
    case (kind_q)
      u8xe_pkg::KIND_ASCII: gen_byte = {1'b0, sr_q[6:0]};
      u8xe_pkg::KIND_UTF: begin
        if (first_q) gen_byte = marker_q | {2'b00, top_digit};
        else         gen_byte = u8xe_pkg::CONT_TAG | {2'b00, top_digit};
      end
      default: gen_byte = u8xe_pkg::entity_byte(kind_q, idx_q);
    endcase
  end

  always_comb begin
    busy_d       = busy_q;
    rem_d        = rem_q;
    idx_d        = idx_q;
    first_d      = first_q;
    kind_d       = kind_q;
    marker_d     = marker_q;
    sr_d         = sr_q;
    lastc_d      = lastc_q;
    out_valid_d  = out_valid_q;
    out_byte_d   = out_byte_q;
    last_byte_d  = last_byte_q;
    string_end_d = string_end_q;

    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    if (gen) begin
      out_valid_d  = 1'b1;
      out_byte_d   = gen_byte;
      last_byte_d  = (rem_q == 3'd1);
      string_end_d = (rem_q == 3'd1) && lastc_q;
      // advance to the next digit
      sr_d    = sr_q << DW;
      rem_d   = rem_q - 3'd1;
      idx_d   = idx_q + 3'd1;
      first_d = 1'b0;
      if (rem_q == 3'd1) busy_d = 1'b0;
    end

    if (accept) begin
      busy_d   = 1'b1;
      idx_d    = 3'd0;
      first_d  = 1'b1;
      lastc_d  = last_char_i;
      marker_d = u8xe_pkg::lead_marker(n_len);
      sr_d     = cp_ext;
      if (code_point_i == 31'(u8xe_pkg::CHAR_AMP)) begin
        kind_d = u8xe_pkg::KIND_AMP;
        rem_d  = 3'd5;
      end else if (code_point_i == 31'(u8xe_pkg::CHAR_LT)) begin
        kind_d = u8xe_pkg::KIND_LT;
        rem_d  = 3'd4;
      end else if (code_point_i == 31'(u8xe_pkg::CHAR_GT)) begin
        kind_d = u8xe_pkg::KIND_GT;
        rem_d  = 3'd4;
      end else if (n_len == 3'd1) begin
        kind_d = u8xe_pkg::KIND_ASCII;
        rem_d  = 3'd1;
      end else begin
        kind_d = u8xe_pkg::KIND_UTF;
        rem_d  = n_len;
        // left-align so the lead digit sits in the top slot
        case (n_len)
          3'd2:    sr_d = cp_ext << (DW * 4);
          3'd3:    sr_d = cp_ext << (DW * 3);
          3'd4:    sr_d = cp_ext << (DW * 2);
          3'd5:    sr_d = cp_ext << DW;
          default: sr_d = cp_ext;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rem_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    first_q      <= first_d;
    kind_q       <= kind_d;
    marker_q     <= marker_d;
    sr_q         <= sr_d;
    lastc_q      <= lastc_d;
    out_byte_q   <= out_byte_d;
    last_byte_q  <= last_byte_d;
    string_end_q <= string_end_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign last_byte_o  = last_byte_q;
  assign string_end_o = string_end_q;

`ifndef SYNTHESIS
  a_busy_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q != 3'd0))
    else $error("encoder busy with no bytes left");

  a_end_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && string_end_o) |-> last_byte_o)
    else $error("string end flagged on a non-final byte");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (busy_q && rem_q != 3'd0))
    else $error("accepted transaction did not start encoding");
`endif

endmodule
